/* rtl/wac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wac_pkg;

	// Default sizes of the block.
	localparam int MAX_CLASSES = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int TOTAL_BITS  = 48;

	// Fixed field widths of the channels and of the configuration port.
	localparam int SUP_W     = 16;
	localparam int SCORE_W   = 16;
	localparam int COL_W     = 6;
	localparam int OUT_W     = 48;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_CLASS   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CNT_W-1:0] CLASS_COUNT_RST = 7'd64;
	localparam logic             PER_CLASS_RST   = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIN,
		ST_RD,
		ST_LD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fin;
		logic rd_issue;
		logic rd_load;
		logic clear_all;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_done;
		logic fin_mend;
		logic rd_last;
	} status_t;

endpackage

`default_nettype wire

/* rtl/wac_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wac_item_if;
	logic                                valid;
	logic                                ready;
	logic        [wac_pkg::SUP_W-1:0]   sup_value;
	logic signed [wac_pkg::SCORE_W-1:0] out_value;
	logic        [wac_pkg::COL_W-1:0]   column;
	logic                                row_end;
	logic                                matrix_end;

	modport source (
		output valid, sup_value, out_value, column, row_end, matrix_end,
		input  ready
	);

	modport sink (
		input  valid, sup_value, out_value, column, row_end, matrix_end,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/wac_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wac_result_if;
	logic                        valid;
	logic                        ready;
	logic [wac_pkg::OUT_W-1:0]  overall_weight;
	logic [wac_pkg::OUT_W-1:0]  total_correct;
	logic [wac_pkg::COL_W-1:0]  class_index;
	logic [wac_pkg::OUT_W-1:0]  class_weight;
	logic [wac_pkg::OUT_W-1:0]  class_correct;
	logic                        last;

	modport source (
		output valid, overall_weight, total_correct, class_index, class_weight,
		       class_correct, last,
		input  ready
	);

	modport sink (
		input  valid, overall_weight, total_correct, class_index, class_weight,
		       class_correct, last,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/wac_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wac_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/wac_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module wac_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	output logic                  res_valid,
	input  wire logic             res_ready,
	input  wire wac_pkg::status_t status,
	output wac_pkg::cmd_t         cmd
);

	wac_pkg::state_t state_q;
	wac_pkg::state_t state_d;
	logic            res_valid_q;
	logic            out_free;

	// The output register can take a new result when it is empty or drained now.
	assign out_free = !res_valid_q || res_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wac_pkg::ST_IDLE: begin
				if (item_valid && status.row_done) begin
					state_d = wac_pkg::ST_FIN;
				end
			end
			wac_pkg::ST_FIN: begin
				state_d = status.fin_mend ? wac_pkg::ST_RD : wac_pkg::ST_IDLE;
			end
			wac_pkg::ST_RD: begin
				if (out_free) begin
					state_d = wac_pkg::ST_LD;
				end
			end
			wac_pkg::ST_LD: begin
				state_d = status.rd_last ? wac_pkg::ST_IDLE : wac_pkg::ST_RD;
			end
			default: begin
				state_d = wac_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		item_ready    = (state_q == wac_pkg::ST_IDLE);
		cmd           = '0;
		cmd.accept    = (state_q == wac_pkg::ST_IDLE) && item_valid;
		cmd.fin       = (state_q == wac_pkg::ST_FIN);
		cmd.rd_issue  = (state_q == wac_pkg::ST_RD) && out_free;
		cmd.rd_load   = (state_q == wac_pkg::ST_LD);
		cmd.clear_all = (state_q == wac_pkg::ST_LD) && status.rd_last;
	end

	assign res_valid = res_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wac_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rd_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A transaction that ends a row is always followed by the total update.
	a_row_end_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.row_done) |=> (state_q == wac_pkg::ST_FIN))
		else $error("row end not followed by total update");

	// A result is never loaded over one that still waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wac_pkg::ST_LD) |-> !res_valid_q)
		else $error("result register overwritten");

	// Every load presents a result in the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wac_pkg::ST_LD) |=> res_valid_q)
		else $error("loaded result not presented");

	// Readout only starts after the update of a matrix end.
	a_rd_entry: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == wac_pkg::ST_FIN && state_q == wac_pkg::ST_RD)
		|-> $past(status.fin_mend))
		else $error("readout without matrix end");
`endif

endmodule

`default_nettype wire

/* rtl/wac_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module wac_dp #(
	parameter int MAX_CLASSES = wac_pkg::MAX_CLASSES,
	parameter int WEIGHT_BITS = wac_pkg::WEIGHT_BITS,
	parameter int TOTAL_BITS  = wac_pkg::TOTAL_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration writes.
	input  wire logic                                cfg_we,
	input  wire logic [wac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [wac_pkg::CNT_W-1:0]           cfg_data,
	// Input item fields.
	input  wire logic [wac_pkg::SUP_W-1:0]           sup_value,
	input  wire logic signed [wac_pkg::SCORE_W-1:0]  out_value,
	input  wire logic [wac_pkg::COL_W-1:0]           column,
	input  wire logic                                row_end,
	input  wire logic                                matrix_end,
	// Control.
	input  wire wac_pkg::cmd_t                       cmd,
	output wac_pkg::status_t                         status,
	// Per-class store memory.
	output logic                                     ram_we,
	output logic [$clog2(MAX_CLASSES)-1:0]           ram_waddr,
	output logic [2*TOTAL_BITS-1:0]                  ram_wdata,
	output logic [$clog2(MAX_CLASSES)-1:0]           ram_raddr,
	input  wire logic [2*TOTAL_BITS-1:0]             ram_rdata,
	// Result fields.
	output logic [wac_pkg::OUT_W-1:0]                overall_weight,
	output logic [wac_pkg::OUT_W-1:0]                total_correct,
	output logic [wac_pkg::COL_W-1:0]                class_index,
	output logic [wac_pkg::OUT_W-1:0]                class_weight,
	output logic [wac_pkg::OUT_W-1:0]                class_correct,
	output logic                                     last
);

	localparam int AW    = $clog2(MAX_CLASSES);
	localparam int NW    = $clog2(MAX_CLASSES + 1);
	localparam int RW    = WEIGHT_BITS + 6;
	localparam int SupW  = wac_pkg::SUP_W;
	localparam int ColW  = wac_pkg::COL_W;
	localparam int CntW  = wac_pkg::CNT_W;
	localparam int OutW  = wac_pkg::OUT_W;
	localparam int SW    = ((RW > SupW) ? RW : SupW) + 1;
	localparam int XW    = ((TOTAL_BITS > RW) ? TOTAL_BITS : RW) + 1;
	localparam int CW    = (ColW > NW) ? ColW : NW;

	localparam logic [RW-1:0]         ROW_MAX = '1;
	localparam logic [TOTAL_BITS-1:0] TOT_MAX = '1;
	localparam logic [NW-1:0]         N_MAX   = NW'(MAX_CLASSES);
	localparam logic [CntW-1:0]       CNT_MAX = CntW'(MAX_CLASSES);

	// Saturating add of a row sum to a total.
	function automatic logic [TOTAL_BITS-1:0] sat_total(
		input logic [TOTAL_BITS-1:0] a,
		input logic [RW-1:0]         b
	);
		logic [XW-1:0] s;
		s = XW'(a) + XW'(b);
		if (s > XW'(TOT_MAX)) begin
			return TOT_MAX;
		end
		return TOTAL_BITS'(s);
	endfunction

	logic [CntW-1:0]              count_q;
	logic                         pc_q;
	logic [NW-1:0]                n_eff;
	logic                         counted;

	logic [SupW-1:0]              sup_best_q;
	logic [AW-1:0]                sup_idx_q;
	logic signed [wac_pkg::SCORE_W-1:0] out_best_q;
	logic [AW-1:0]                out_idx_q;
	logic                         started_q;
	logic [RW-1:0]                row_sum_q;

	logic [SW-1:0]                rs_wide;
	logic [RW-1:0]                rs_sat;
	logic                         take_sup;
	logic                         take_out;
	logic [RW-1:0]                m_sum;
	logic [AW-1:0]                m_sidx;
	logic [AW-1:0]                m_oidx;
	logic [SupW-1:0]              m_sbest;
	logic signed [wac_pkg::SCORE_W-1:0] m_obest;
	logic                         row_done;

	logic [RW-1:0]                fin_sum_q;
	logic [AW-1:0]                fin_k_q;
	logic                         fin_agree_q;
	logic                         fin_mend_q;

	logic [TOTAL_BITS-1:0]        wt_q;
	logic [TOTAL_BITS-1:0]        ct_q;
	logic [MAX_CLASSES-1:0]       valid_q;
	logic [AW-1:0]                rd_k_q;
	logic                         rd_last;

	logic [TOTAL_BITS-1:0]        old_w;
	logic [TOTAL_BITS-1:0]        old_c;
	logic [TOTAL_BITS-1:0]        rd_w;
	logic [TOTAL_BITS-1:0]        rd_c;

	// Configuration register decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= wac_pkg::CLASS_COUNT_RST;
			pc_q    <= wac_pkg::PER_CLASS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wac_pkg::CFG_CLASS_COUNT: count_q <= cfg_data;
				wac_pkg::CFG_PER_CLASS:   pc_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Class count in use, clamped to one through the store depth.
	always_comb begin
		if (count_q == '0) begin
			n_eff = NW'(1);
		end else if (count_q > CNT_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = NW'(count_q);
		end
	end

	assign counted  = CW'(column) < CW'(n_eff);
	assign row_done = row_end || matrix_end;

	// Row state merged with the element of the current transaction.
	always_comb begin
		rs_wide  = SW'(row_sum_q) + SW'(sup_value);
		rs_sat   = (rs_wide > SW'(ROW_MAX)) ? ROW_MAX : RW'(rs_wide);
		take_sup = counted && (!started_q || (sup_value > sup_best_q));
		take_out = counted && (!started_q || (out_value > out_best_q));
		m_sum    = counted ? rs_sat : row_sum_q;
		m_sidx   = take_sup ? AW'(column) : sup_idx_q;
		m_sbest  = take_sup ? sup_value : sup_best_q;
		m_oidx   = take_out ? AW'(column) : out_idx_q;
		m_obest  = take_out ? out_value : out_best_q;
	end

	// Running row sum and the two argmax trackers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_best_q <= '0;
			sup_idx_q  <= '0;
			out_best_q <= {1'b1, {(wac_pkg::SCORE_W-1){1'b0}}};
			out_idx_q  <= '0;
			started_q  <= 1'b0;
			row_sum_q  <= '0;
			fin_mend_q <= 1'b0;
		end else if (cmd.accept) begin
			if (row_done) begin
				sup_best_q <= '0;
				sup_idx_q  <= '0;
				out_best_q <= {1'b1, {(wac_pkg::SCORE_W-1){1'b0}}};
				out_idx_q  <= '0;
				started_q  <= 1'b0;
				row_sum_q  <= '0;
				fin_mend_q <= matrix_end;
			end else begin
				sup_best_q <= m_sbest;
				sup_idx_q  <= m_sidx;
				out_best_q <= m_obest;
				out_idx_q  <= m_oidx;
				started_q  <= started_q || counted;
				row_sum_q  <= m_sum;
			end
		end
	end

	// Finished row, held for the update of the totals.
	always_ff @(posedge clk) begin
		if (cmd.accept && row_done) begin
			fin_sum_q   <= m_sum;
			fin_k_q     <= m_sidx;
			fin_agree_q <= (m_sidx == m_oidx);
		end
	end

	// The store entry of the finishing row is read as the row ends.
	assign ram_raddr = cmd.accept ? m_sidx : rd_k_q;

	// Per-class read-modify-write; entries never written since a clear read as zero.
	always_comb begin
		old_w     = valid_q[fin_k_q] ? ram_rdata[TOTAL_BITS-1:0] : '0;
		old_c     = valid_q[fin_k_q] ? ram_rdata[2*TOTAL_BITS-1:TOTAL_BITS] : '0;
		ram_we    = cmd.fin && pc_q;
		ram_waddr = fin_k_q;
		ram_wdata = {(fin_agree_q ? sat_total(old_c, fin_sum_q) : old_c),
		             sat_total(old_w, fin_sum_q)};
	end

	// Totals, store valid bits and the readout counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q    <= '0;
			ct_q    <= '0;
			valid_q <= '0;
			rd_k_q  <= '0;
		end else begin
			if (cmd.clear_all) begin
				wt_q    <= '0;
				ct_q    <= '0;
				valid_q <= '0;
			end else if (cmd.fin) begin
				wt_q <= sat_total(wt_q, fin_sum_q);
				if (fin_agree_q) begin
					ct_q <= sat_total(ct_q, fin_sum_q);
				end
				if (pc_q) begin
					valid_q[fin_k_q] <= 1'b1;
				end
			end
			if (cmd.fin) begin
				rd_k_q <= '0;
			end else if (cmd.rd_load) begin
				rd_k_q <= rd_k_q + AW'(1);
			end
		end
	end

	assign rd_last = !pc_q || ((NW'(rd_k_q) + NW'(1)) == n_eff);

	// Store data of the entry being read out.
	always_comb begin
		rd_w = (pc_q && valid_q[rd_k_q]) ? ram_rdata[TOTAL_BITS-1:0] : '0;
		rd_c = (pc_q && valid_q[rd_k_q]) ? ram_rdata[2*TOTAL_BITS-1:TOTAL_BITS] : '0;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			overall_weight <= OutW'(wt_q);
			total_correct  <= OutW'(ct_q);
			class_index    <= pc_q ? ColW'(rd_k_q) : '0;
			class_weight   <= OutW'(rd_w);
			class_correct  <= OutW'(rd_c);
			last           <= rd_last;
		end
	end

	// Status to the controller.
	always_comb begin
		status          = '0;
		status.row_done = row_done;
		status.fin_mend = fin_mend_q;
		status.rd_last  = rd_last;
	end

endmodule

`default_nettype wire

/* rtl/weighted_argmax_accuracy_top.sv */
// Elements that do not end a row keep the block idle; a new one is taken each idle cycle.
// A row end enters the update state; the per-class store read-modify-write holds off input.
// Matrix end: after the update, each result takes a memory read state, waiting for a free output
// register, and a load state: one result per class in use, or one when per-class is off.
// Reset sets default config, clears row state, totals and store valid bits; not memory data.
`timescale 1ns / 1ps
`default_nettype none

module weighted_argmax_accuracy_top #(
	parameter int MAX_CLASSES = wac_pkg::MAX_CLASSES,
	parameter int WEIGHT_BITS = wac_pkg::WEIGHT_BITS,
	parameter int TOTAL_BITS  = wac_pkg::TOTAL_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	wac_item_if.sink                           item,
	wac_result_if.source                       result,
	input  wire logic                          cfg_we,
	input  wire logic [wac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wac_pkg::CNT_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_CLASSES);

	wac_pkg::cmd_t          cmd;
	wac_pkg::status_t       status;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [2*TOTAL_BITS-1:0] ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [2*TOTAL_BITS-1:0] ram_rdata;

	// Sequencing of rows, updates and readout.
	wac_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Row tracking, totals and the result register.
	wac_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.TOTAL_BITS  (TOTAL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sup_value      (item.sup_value),
		.out_value      (item.out_value),
		.column         (item.column),
		.row_end        (item.row_end),
		.matrix_end     (item.matrix_end),
		.cmd            (cmd),
		.status         (status),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.overall_weight (result.overall_weight),
		.total_correct  (result.total_correct),
		.class_index    (result.class_index),
		.class_weight   (result.class_weight),
		.class_correct  (result.class_correct),
		.last           (result.last)
	);

	// Per-class weight and correct totals, one word per class.
	wac_ram #(
		.WIDTH (2 * TOTAL_BITS),
		.DEPTH (MAX_CLASSES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* sim/tb_weighted_argmax_accuracy_top.sv */
`timescale 1ns / 1ps

module tb_weighted_argmax_accuracy_top;
	import wac_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 12;
	localparam int END_WAIT        = 200;
	localparam int RANDOM_ELEMENTS = 360;

	// One readout transaction as the block should produce it.
	typedef struct {
		logic [OUT_W-1:0] overall_weight;
		logic [OUT_W-1:0] total_correct;
		logic [COL_W-1:0] class_index;
		logic [OUT_W-1:0] class_weight;
		logic [OUT_W-1:0] class_correct;
		logic             last;
	} readout_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	wac_item_if   item_ch ();
	wac_result_if res_ch ();

	weighted_argmax_accuracy_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Accuracy predictor state: configuration, row tracking, totals and class stores.
	logic [CNT_W-1:0]          cfg_count;
	logic                      per_class_on;
	logic [SUP_W-1:0]          best_sup;
	logic [COL_W-1:0]          best_sup_col;
	logic signed [SCORE_W-1:0] best_score;
	logic [COL_W-1:0]          best_score_col;
	logic                      row_open;
	logic [WEIGHT_BITS+5:0]    row_weight;
	logic [OUT_W-1:0]          weight_sum;
	logic [OUT_W-1:0]          correct_sum;
	logic [OUT_W-1:0]          class_weight_mem [MAX_CLASSES];
	logic [OUT_W-1:0]          class_correct_mem [MAX_CLASSES];

	readout_t expected_readout [$];
	int       mismatch_count;
	int       counted_elements;
	int       burst_left;
	bit       gaps_enabled;
	bit       hold_off_request;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int active_classes();
		if (cfg_count == 0) begin
			return 1;
		end
		if (cfg_count > MAX_CLASSES) begin
			return MAX_CLASSES;
		end
		return int'(cfg_count);
	endfunction

	function automatic logic [OUT_W-1:0] add_sat(input logic [OUT_W-1:0] a,
		input logic [OUT_W-1:0] b);
		logic [OUT_W:0] s;
		s = (OUT_W+1)'(a) + (OUT_W+1)'(b);
		return s[OUT_W] ? '1 : s[OUT_W-1:0];
	endfunction

	function automatic void clear_row();
		best_sup       = '0;
		best_sup_col   = '0;
		best_score     = 16'sh8000;
		best_score_col = '0;
		row_open       = 1'b0;
		row_weight     = '0;
	endfunction

	function automatic void reset_model();
		cfg_count    = CLASS_COUNT_RST;
		per_class_on = PER_CLASS_RST;
		clear_row();
		weight_sum  = '0;
		correct_sum = '0;
		foreach (class_weight_mem[c]) begin
			class_weight_mem[c]  = '0;
			class_correct_mem[c] = '0;
		end
	endfunction

	// Update the accuracy state with one element and queue any readout it triggers.
	function automatic void predict_element(input logic [SUP_W-1:0] sup,
		input logic signed [SCORE_W-1:0] score, input logic [COL_W-1:0] col,
		input logic rend, input logic mend);
		int n;
		logic [WEIGHT_BITS+6:0] row_next;
		logic agree;
		readout_t entry;
		n = active_classes();
		if (col < n) begin
			row_next = (WEIGHT_BITS+7)'(row_weight) + (WEIGHT_BITS+7)'(sup);
			row_weight = row_next[WEIGHT_BITS+6] ? '1 : row_next[WEIGHT_BITS+5:0];
			// The first maximum in arrival order wins a tie.
			if (!row_open || sup > best_sup) begin
				best_sup     = sup;
				best_sup_col = col;
			end
			if (!row_open || score > best_score) begin
				best_score     = score;
				best_score_col = col;
			end
			row_open = 1'b1;
		end
		// A matrix end also closes the current row.
		if (rend || mend) begin
			agree = (best_sup_col == best_score_col);
			weight_sum = add_sat(weight_sum, OUT_W'(row_weight));
			if (agree) begin
				correct_sum = add_sat(correct_sum, OUT_W'(row_weight));
			end
			if (per_class_on) begin
				class_weight_mem[best_sup_col] = add_sat(class_weight_mem[best_sup_col],
					OUT_W'(row_weight));
				if (agree) begin
					class_correct_mem[best_sup_col] =
						add_sat(class_correct_mem[best_sup_col], OUT_W'(row_weight));
				end
			end
			clear_row();
		end
		if (mend) begin
			entry.overall_weight = weight_sum;
			entry.total_correct  = correct_sum;
			if (per_class_on) begin
				for (int c = 0; c < n; c++) begin
					entry.class_index   = COL_W'(c);
					entry.class_weight  = class_weight_mem[c];
					entry.class_correct = class_correct_mem[c];
					entry.last          = (c == n - 1);
					expected_readout.push_back(entry);
				end
			end else begin
				entry.class_index   = '0;
				entry.class_weight  = '0;
				entry.class_correct = '0;
				entry.last          = 1'b1;
				expected_readout.push_back(entry);
			end
			// Totals and every class store are cleared by the readout.
			weight_sum  = '0;
			correct_sum = '0;
			foreach (class_weight_mem[c]) begin
				class_weight_mem[c]  = '0;
				class_correct_mem[c] = '0;
			end
		end
	endfunction

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare every accepted readout transaction with the oldest prediction.
	always @(posedge clk) begin : readout_checker
		readout_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_readout.size() == 0) begin
				$error("readout transaction arrived with nothing expected");
				mismatch_count++;
			end else begin
				want = expected_readout.pop_front();
				check_field("overall_weight", want.overall_weight, res_ch.overall_weight);
				check_field("total_correct", want.total_correct, res_ch.total_correct);
				check_field("class_index", OUT_W'(want.class_index),
					OUT_W'(res_ch.class_index));
				check_field("class_weight", want.class_weight, res_ch.class_weight);
				check_field("class_correct", want.class_correct, res_ch.class_correct);
				check_field("last", OUT_W'(want.last), OUT_W'(res_ch.last));
			end
		end
	end

	// The receiver changes its stall pattern now and then, and honors one long hold-off.
	initial begin : readout_receiver
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_request = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				tick++;
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					2: res_ch.ready <= ($urandom_range(0, 9) < 3);
					default: res_ch.ready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	// End the run when no transaction has moved on either channel for too long.
	initial begin : stall_watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Some tests failed");
		$finish;
	end

	// Offer one element and wait for its transaction; called and left at a falling edge.
	task automatic send_element(input logic [SUP_W-1:0] sup,
		input logic signed [SCORE_W-1:0] score, input logic [COL_W-1:0] col,
		input logic rend, input logic mend);
		if (gaps_enabled && burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 80)
				: $urandom_range(1, 12);
		end
		item_ch.valid      <= 1'b1;
		item_ch.sup_value  <= sup;
		item_ch.out_value  <= score;
		item_ch.column     <= col;
		item_ch.row_end    <= rend;
		item_ch.matrix_end <= mend;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (col < active_classes()) begin
			counted_elements++;
		end
		predict_element(sup, score, col, rend, mend);
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
	endtask

	// Let the block go idle: every readout in, then time for a pending row update.
	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_readout.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reconfigure(input logic [CNT_W-1:0] count, input logic enable);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLASS_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= CFG_PER_CLASS;
		cfg_data  <= {{(CNT_W-1){1'b0}}, enable};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_count    = count;
		per_class_on = enable;
	endtask

	function automatic logic [SUP_W-1:0] random_weight();
		case ($urandom_range(0, 5))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2, 3: return SUP_W'($urandom_range(0, 3));
			default: return SUP_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [SCORE_W-1:0] random_score();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return SCORE_W'($urandom_range(0, 2)) - 16'sd1;
			default: return SCORE_W'($urandom);
		endcase
	endfunction

	// Send one row: mostly well formed, sometimes scrambled or noisy.
	task automatic send_row(input bit last_row);
		int n;
		int len;
		int kind;
		logic [COL_W-1:0] col;
		logic rend;
		n = active_classes();
		kind = $urandom_range(0, 9);
		len = (kind < 7) ? n : $urandom_range(1, n + 3);
		for (int e = 0; e < len; e++) begin
			rend = (e == len - 1);
			if (kind < 5) begin
				col = COL_W'(e);
			end else if (kind < 7) begin
				col = COL_W'(n - 1 - e);
			end else if (kind < 9) begin
				col = COL_W'($urandom_range(0, n - 1));
			end else begin
				// Noise: any column, and row ends in odd places.
				col = COL_W'($urandom_range(0, 63));
				rend = rend || ($urandom_range(0, 7) == 0);
			end
			send_element(random_weight(), random_score(), col, rend,
				last_row && (e == len - 1));
		end
	endtask

	task automatic send_matrix(input int rows);
		for (int r = 0; r < rows; r++) begin
			send_row(r == rows - 1);
		end
	endtask

	function automatic logic [CNT_W-1:0] random_class_count();
		case ($urandom_range(0, 15))
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd0;
			3: return CNT_W'($urandom_range(65, 127));
			4: return CNT_W'($urandom_range(17, 63));
			default: return CNT_W'($urandom_range(2, 12));
		endcase
	endfunction

	// Field extremes, ties on both argmaxes, agreement and disagreement, reset settings.
	task automatic test_directed_extremes();
		send_element(16'hFFFF, 16'sh7FFF, 6'd63, 1'b0, 1'b0);
		send_element(16'h0000, 16'sh8000, 6'd0, 1'b0, 1'b0);
		send_element(16'hFFFF, 16'sh7FFF, 6'd5, 1'b1, 1'b0);
		send_element(16'd100, 16'sh8000, 6'd3, 1'b0, 1'b0);
		send_element(16'd100, 16'sh8000, 6'd7, 1'b1, 1'b0);
		send_element(16'd5, 16'sd10, 6'd1, 1'b0, 1'b0);
		send_element(16'd9, 16'sd3, 6'd2, 1'b1, 1'b0);
		send_element(16'h0000, 16'sh0000, 6'd0, 1'b0, 1'b1);
	endtask

	// Columns beyond the class count are ignored but their row marks still act.
	task automatic test_unused_columns();
		reconfigure(7'd4, 1'b1);
		send_element(16'd1000, 16'sd5, 6'd10, 1'b0, 1'b0);
		send_element(16'h0000, 16'sh0000, 6'd63, 1'b1, 1'b0);
		send_element(16'd300, 16'shFFFF, 6'd2, 1'b0, 1'b0);
		send_element(16'd300, 16'shFFFE, 6'd3, 1'b1, 1'b0);
		send_element(16'd7, 16'sd7, 6'd60, 1'b0, 1'b1);
	endtask

	// A zero count acts as one, counts above the maximum act as the maximum.
	task automatic test_class_count_limits();
		reconfigure(7'd0, 1'b1);
		send_element(16'd50, 16'sd1, 6'd0, 1'b0, 1'b0);
		send_element(16'd60, 16'sd2, 6'd1, 1'b0, 1'b1);
		reconfigure(7'd127, 1'b0);
		send_element(16'hFFFF, 16'shFFFF, 6'd63, 1'b1, 1'b1);
		reconfigure(7'd100, 1'b1);
		send_element(16'h8000, 16'sh7FFF, 6'd40, 1'b0, 1'b1);
	endtask

	// A long row of heavy weights drives the row sum into saturation.
	task automatic test_row_sum_saturation();
		reconfigure(7'd2, 1'b1);
		for (int e = 0; e < 70; e++) begin
			send_element(16'hFFFF - SUP_W'($urandom_range(0, 15)), random_score(),
				COL_W'($urandom_range(0, 1)), e == 69, e == 69);
		end
	endtask

	// The receiver holds off while matrices keep coming, so the input must stall.
	task automatic test_readout_backpressure();
		reconfigure(7'd8, 1'b1);
		gaps_enabled = 1'b0;
		hold_off_request = 1'b1;
		repeat (3) send_matrix(2);
		gaps_enabled = 1'b1;
		burst_left = 0;
	endtask

	// Random matrices under changing settings, sometimes back to back.
	task automatic test_random_matrices();
		int n;
		int rows;
		counted_elements = 0;
		while (counted_elements < RANDOM_ELEMENTS) begin
			if ($urandom_range(0, 3) != 0) begin
				reconfigure(random_class_count(), 1'($urandom_range(0, 1)));
			end
			n = active_classes();
			if (n <= 4) begin
				rows = $urandom_range(1, 10);
			end else if (n <= 16) begin
				rows = $urandom_range(1, 4);
			end else begin
				rows = 1;
			end
			send_matrix(rows);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_CLASS_COUNT;
		cfg_data           = '0;
		item_ch.valid      = 1'b0;
		item_ch.sup_value  = '0;
		item_ch.out_value  = '0;
		item_ch.column     = '0;
		item_ch.row_end    = 1'b0;
		item_ch.matrix_end = 1'b0;
		mismatch_count     = 0;
		counted_elements   = 0;
		burst_left         = 0;
		gaps_enabled       = 1'b1;
		hold_off_request   = 1'b0;
		reset_model();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_unused_columns();
		test_class_count_limits();
		test_row_sum_saturation();
		test_readout_backpressure();
		test_random_matrices();

		// Wait for every readout, then watch for stray transactions.
		wait_for_drain();
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
